### design/csvt_pkg.sv
// Shared types, codes and character constants of the CSV record tokenizer.
`default_nettype none

package csvt_pkg;

	// Input item kinds.
	localparam logic [1:0] KIND_CHAR    = 2'd0;
	localparam logic [1:0] KIND_NEWLINE = 2'd1;
	localparam logic [1:0] KIND_EOS     = 2'd2;

	// Result item kinds.
	localparam logic [1:0] OK_CHAR       = 2'd0;
	localparam logic [1:0] OK_FIELD_END  = 2'd1;
	localparam logic [1:0] OK_RECORD_END = 2'd2;
	localparam logic [1:0] OK_MALFORMED  = 2'd3;

	// Characters with a special meaning.
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	// Default number of entries in the result queue.
	localparam int CSVT_FIFO_DEPTH = 4;

	// Parser flags carried from one item to the next.
	typedef struct packed {
		logic in_quotes;
		logic quote_pending;
		logic quote_done;
		logic field_nonempty;
		logic cr_pending;
		logic line_started;
		logic skipping_line;
	} csvt_state_t;

	// One result item.
	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] out_char;
		logic       last;
	} csvt_result_t;

	// Everything one item produces: next flags and up to two results.
	typedef struct packed {
		csvt_state_t  st;
		logic [1:0]   cnt;
		csvt_result_t r0;
		csvt_result_t r1;
	} csvt_work_t;

endpackage : csvt_pkg

`default_nettype wire

### design/csvt_step.sv
// Combinational next-state and result logic for one registered input item.
`default_nettype none

module csvt_step
	import csvt_pkg::*;
(
	input  wire csvt_state_t st_in,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  chr,
	output csvt_work_t       work
);

	// Append one result, at most two per item.
	function automatic csvt_work_t emit(input csvt_work_t w, input logic [1:0] k,
			input logic [7:0] c);
		csvt_work_t r;
		r = w;
		if (w.cnt == 2'd0) begin
			r.r0 = '{out_kind: k, out_char: c, last: 1'b0};
			r.cnt = 2'd1;
		end else if (w.cnt == 2'd1) begin
			r.r1 = '{out_kind: k, out_char: c, last: 1'b0};
			r.cnt = 2'd2;
		end
		return r;
	endfunction

	// Clear the flags of the current record.
	function automatic csvt_state_t clear_record(input csvt_state_t s);
		csvt_state_t r;
		r = s;
		r.in_quotes      = 1'b0;
		r.quote_pending  = 1'b0;
		r.quote_done     = 1'b0;
		r.field_nonempty = 1'b0;
		r.cr_pending     = 1'b0;
		r.line_started   = 1'b0;
		return r;
	endfunction

	// Handle one ordinary byte of a record.
	function automatic csvt_work_t take_byte(input csvt_work_t w_in, input logic [7:0] c);
		csvt_work_t w;
		w = w_in;
		if (w.st.skipping_line) begin
			return w;
		end
		w.st.line_started = 1'b1;
		if (w.st.quote_pending) begin
			w.st.quote_pending = 1'b0;
			if (c == CH_QUOTE) begin
				return emit(w, OK_CHAR, CH_QUOTE);
			end
			w.st.in_quotes  = 1'b0;
			w.st.quote_done = 1'b1;
		end else if (w.st.in_quotes) begin
			if (c == CH_QUOTE) begin
				w.st.quote_pending = 1'b1;
				return w;
			end
			return emit(w, OK_CHAR, c);
		end
		if (w.st.quote_done && (c != CH_COMMA)) begin
			w = emit(w, OK_MALFORMED, 8'h00);
			w.st = clear_record(w.st);
			w.st.skipping_line = 1'b1;
			return w;
		end
		if (c == CH_COMMA) begin
			w = emit(w, OK_FIELD_END, 8'h00);
			w.st.quote_done     = 1'b0;
			w.st.field_nonempty = 1'b0;
		end else if ((c == CH_QUOTE) && !w.st.field_nonempty) begin
			w.st.in_quotes = 1'b1;
		end else begin
			w = emit(w, OK_CHAR, c);
			w.st.field_nonempty = 1'b1;
		end
		return w;
	endfunction

	// A quote seen just before a line end is a closing quote.
	function automatic csvt_state_t resolve_quote(input csvt_state_t s);
		csvt_state_t r;
		r = s;
		if (s.quote_pending) begin
			r.quote_pending = 1'b0;
			r.in_quotes     = 1'b0;
			r.quote_done    = 1'b1;
		end
		return r;
	endfunction

	// Dispatch on the item kind, then mark the final result.
	always_comb begin
		work = '0;
		work.st = st_in;
		case (kind)
			KIND_CHAR: begin
				if (!work.st.skipping_line) begin
					if (work.st.cr_pending) begin
						work.st.cr_pending = 1'b0;
						work = take_byte(work, CH_CR);
					end
					if (!work.st.skipping_line) begin
						if (chr == CH_CR) begin
							work.st.cr_pending   = 1'b1;
							work.st.line_started = 1'b1;
						end else begin
							work = take_byte(work, chr);
						end
					end
				end
			end
			KIND_NEWLINE: begin
				work.st.cr_pending = 1'b0;
				if (work.st.skipping_line) begin
					work.st = clear_record(work.st);
					work.st.skipping_line = 1'b0;
				end else begin
					work.st = resolve_quote(work.st);
					if (work.st.in_quotes) begin
						work = emit(work, OK_CHAR, CH_LF);
					end else begin
						work = emit(work, OK_RECORD_END, 8'h00);
						work.st = clear_record(work.st);
					end
				end
			end
			KIND_EOS: begin
				work.st.cr_pending = 1'b0;
				if (!work.st.skipping_line) begin
					work.st = resolve_quote(work.st);
					if (work.st.in_quotes) begin
						work = emit(work, OK_MALFORMED, 8'h00);
					end else if (work.st.line_started) begin
						work = emit(work, OK_RECORD_END, 8'h00);
					end
				end
				work.st = clear_record(work.st);
				work.st.skipping_line = 1'b0;
			end
			default: begin
			end
		endcase
		if (work.cnt == 2'd1) begin
			work.r0.last = 1'b1;
		end else if (work.cnt == 2'd2) begin
			work.r1.last = 1'b1;
		end
	end

endmodule : csvt_step

`default_nettype wire

### design/csvt_result_fifo.sv
// Small register queue of result items: up to two writes in, one read out per cycle.
`default_nettype none

module csvt_result_fifo
	import csvt_pkg::*;
#(
	parameter int DEPTH = CSVT_FIFO_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [1:0]   push_cnt,
	input  wire csvt_result_t push0,
	input  wire csvt_result_t push1,
	input  wire logic         pop,
	output csvt_result_t      head,
	output logic              not_empty,
	output logic              room2
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	csvt_result_t         mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic [PTR_W-1:0]     wr_ptr_p1;
	logic [PTR_W-1:0]     wr_ptr_p2;
	logic [PTR_W-1:0]     rd_ptr_p1;

	// Pointer step with wrap at the queue depth.
	function automatic logic [PTR_W-1:0] inc_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return r;
	endfunction

	assign wr_ptr_p1 = inc_ptr(wr_ptr_q);
	assign wr_ptr_p2 = inc_ptr(wr_ptr_p1);
	assign rd_ptr_p1 = inc_ptr(rd_ptr_q);

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign room2     = (count_q <= CNT_W'(DEPTH - 2));

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_p1] <= push1;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_cnt == 2'd1) begin
				wr_ptr_q <= wr_ptr_p1;
			end else if (push_cnt == 2'd2) begin
				wr_ptr_q <= wr_ptr_p2;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_p1;
			end
			count_q <= count_q + CNT_W'(push_cnt) - CNT_W'(pop);
		end
	end

endmodule : csvt_result_fifo

`default_nettype wire

### design/csv_record_tokenizer.sv
// Top level of the CSV record tokenizer: input register, parser flags and result queue.
// Path: an item waits in the input register until the queue has room for two results,
// and its results are then offered from the result queue.
// Throughput: one item per cycle while items give at most one result each and the output
// is not stalled; the output port moves one result per cycle.
// The result queue sets how far input can run ahead of a stalled output.
// Reset: arst_n clears all parser flags, the input valid bit and the queue at once.
`default_nettype none

module csv_record_tokenizer
	import csvt_pkg::*;
#(
	parameter int FIFO_DEPTH = CSVT_FIFO_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] char_in
	input  wire logic [1:0] s_axis_tuser,  // [1:0] kind
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [7:0] out_char
	output logic [1:0]      m_axis_tuser,  // [1:0] out_kind
	output logic            m_axis_tlast
);

	logic         valid_s1;
	logic [1:0]   kind_s1;
	logic [7:0]   char_s1;
	csvt_state_t  state_q;
	csvt_work_t   work;
	logic         room2;
	logic         proc;
	logic         not_empty;
	csvt_result_t head;

	// An item in the input register is processed once the queue can take two results.
	assign proc          = valid_s1 && room2;
	assign s_axis_tready = !valid_s1 || proc;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			kind_s1 <= s_axis_tuser;
			char_s1 <= s_axis_tdata;
		end
	end

	// Parser flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (proc) begin
			state_q <= work.st;
		end
	end

	csvt_step u_step (
		.st_in (state_q),
		.kind  (kind_s1),
		.chr   (char_s1),
		.work  (work)
	);

	csvt_result_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (proc ? work.cnt : 2'd0),
		.push0     (work.r0),
		.push1     (work.r1),
		.pop       (m_axis_tvalid && m_axis_tready),
		.head      (head),
		.not_empty (not_empty),
		.room2     (room2)
	);

	// Output transfer.
	assign m_axis_tvalid = not_empty;
	assign m_axis_tdata  = head.out_char;
	assign m_axis_tuser  = head.out_kind;
	assign m_axis_tlast  = head.last;

	// A line is skipped only after the record flags were cleared.
	a_skip_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.skipping_line |-> (!state_q.in_quotes && !state_q.quote_done))
		else $error("skipping a line with record flags set");

	// A pending quote exists only inside a quoted field.
	a_pending_in_quotes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.quote_pending |-> state_q.in_quotes)
		else $error("quote pending outside quotes");

	// A newline outside a skip always yields exactly one result.
	a_newline_one: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && (kind_s1 == KIND_NEWLINE) && !state_q.skipping_line) |-> (work.cnt == 2'd1))
		else $error("newline did not give one result");

endmodule : csv_record_tokenizer

`default_nettype wire

### bench/csv_record_tokenizer_tb.sv
// Self-checking testbench for the CSV record tokenizer: directed and random byte streams.
module csv_record_tokenizer_tb;
	import csvt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 8;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = '0;   // [7:0] char_in
	logic [1:0] s_axis_tuser = '0;   // [1:0] kind
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;        // [7:0] out_char
	logic [1:0] m_axis_tuser;        // [1:0] out_kind
	logic       m_axis_tlast;

	csv_record_tokenizer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int items_sent = 0;
	int fail_count = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;

	// Tokens still to come from the block, oldest first.
	csvt_result_t expected_tokens[$];

	// Parser flags of the predictor.
	bit in_q, q_pend, q_closed, fld_busy, cr_held, line_open, skipping;

	// Tokens produced by the item being predicted.
	csvt_result_t step_tok[2];
	int           step_cnt;

	function void note_token(logic [1:0] k, logic [7:0] c);
		if (step_cnt < 2) begin
			step_tok[step_cnt].out_kind = k;
			step_tok[step_cnt].out_char = c;
			step_tok[step_cnt].last     = 1'b0;
			step_cnt++;
		end
	endfunction

	function void reset_record();
		in_q      = 1'b0;
		q_pend    = 1'b0;
		q_closed  = 1'b0;
		fld_busy  = 1'b0;
		cr_held   = 1'b0;
		line_open = 1'b0;
	endfunction

	// A quote waiting for its partner turns into the closing quote.
	function void settle_quote();
		if (q_pend) begin
			q_pend   = 1'b0;
			in_q     = 1'b0;
			q_closed = 1'b1;
		end
	endfunction

	// One data byte through the field parser.
	function void feed_byte(logic [7:0] c);
		if (skipping)
			return;
		line_open = 1'b1;
		if (q_pend) begin
			q_pend = 1'b0;
			if (c == CH_QUOTE) begin
				note_token(OK_CHAR, CH_QUOTE);
				return;
			end
			in_q     = 1'b0;
			q_closed = 1'b1;
		end else if (in_q) begin
			if (c == CH_QUOTE)
				q_pend = 1'b1;
			else
				note_token(OK_CHAR, c);
			return;
		end
		// Only a comma may follow a closing quote.
		if (q_closed && c != CH_COMMA) begin
			note_token(OK_MALFORMED, 8'h00);
			reset_record();
			skipping = 1'b1;
			return;
		end
		if (c == CH_COMMA) begin
			note_token(OK_FIELD_END, 8'h00);
			q_closed = 1'b0;
			fld_busy = 1'b0;
		end else if (c == CH_QUOTE && !fld_busy) begin
			in_q = 1'b1;
		end else begin
			note_token(OK_CHAR, c);
			fld_busy = 1'b1;
		end
	endfunction

	// Predicts the tokens of one accepted item and queues them.
	function void tokenize_item(logic [1:0] k, logic [7:0] c);
		csvt_result_t t;
		int i;
		step_cnt = 0;
		case (k)
			KIND_CHAR: begin
				if (!skipping) begin
					// A held carriage return is an ordinary byte when data follows.
					if (cr_held) begin
						cr_held = 1'b0;
						feed_byte(CH_CR);
					end
					if (!skipping) begin
						if (c == CH_CR) begin
							cr_held   = 1'b1;
							line_open = 1'b1;
						end else begin
							feed_byte(c);
						end
					end
				end
			end
			KIND_NEWLINE: begin
				cr_held = 1'b0;
				if (skipping) begin
					reset_record();
					skipping = 1'b0;
				end else begin
					settle_quote();
					if (in_q) begin
						note_token(OK_CHAR, CH_LF);
					end else begin
						note_token(OK_RECORD_END, 8'h00);
						reset_record();
					end
				end
			end
			KIND_EOS: begin
				cr_held = 1'b0;
				if (!skipping) begin
					settle_quote();
					if (in_q)
						note_token(OK_MALFORMED, 8'h00);
					else if (line_open)
						note_token(OK_RECORD_END, 8'h00);
				end
				reset_record();
				skipping = 1'b0;
			end
			default: begin
			end
		endcase
		for (i = 0; i < step_cnt; i++) begin
			t      = step_tok[i];
			t.last = (i == step_cnt - 1);
			expected_tokens = {expected_tokens, t};
		end
	endfunction

	// Offers one item, with random idle cycles first, and waits for its transfer.
	task automatic send_item(input logic [1:0] k, input logic [7:0] c);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= k;
		s_axis_tdata  <= c;
		do
			@(posedge clk);
		while (!s_axis_tready);
		tokenize_item(k, c);
		items_sent++;
	endtask

	// Drops the valid for one cycle so the next phase starts on a later edge.
	task automatic stop_sending();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_tokens.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] text_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (c == CH_COMMA || c == CH_QUOTE || c == CH_CR);
		return c;
	endfunction

	// One record with random fields, some quoted, and an occasional stray item.
	task automatic send_record();
		int nf, len, f, j, sel;
		bit quoted;
		nf = $urandom_range(1, 5);
		for (f = 0; f < nf; f++) begin
			if (f > 0)
				send_item(KIND_CHAR, CH_COMMA);
			quoted = ($urandom_range(99) < 40);
			len    = $urandom_range(0, 6);
			if (quoted) begin
				send_item(KIND_CHAR, CH_QUOTE);
				for (j = 0; j < len; j++) begin
					sel = $urandom_range(99);
					if (sel < 12) begin
						send_item(KIND_CHAR, CH_QUOTE);
						send_item(KIND_CHAR, CH_QUOTE);
					end else if (sel < 22) begin
						send_item(KIND_NEWLINE, 8'($urandom_range(255)));
					end else if (sel < 30) begin
						send_item(KIND_CHAR, CH_COMMA);
					end else if (sel < 36) begin
						send_item(KIND_CHAR, CH_CR);
					end else begin
						send_item(KIND_CHAR, text_byte());
					end
				end
				send_item(KIND_CHAR, CH_QUOTE);
			end else begin
				for (j = 0; j < len; j++) begin
					if ($urandom_range(99) < 5)
						send_item(KIND_CHAR, CH_CR);
					else
						send_item(KIND_CHAR, text_byte());
				end
			end
			// Stray items break the record now and then.
			if ($urandom_range(99) < 8)
				send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
		end
		sel = $urandom_range(99);
		if (sel < 70) begin
			send_item(KIND_NEWLINE, 8'($urandom_range(255)));
		end else if (sel < 85) begin
			send_item(KIND_CHAR, CH_CR);
			send_item(KIND_NEWLINE, 8'($urandom_range(255)));
		end else if (sel < 93) begin
			send_item(KIND_EOS, 8'($urandom_range(255)));
		end else begin
			send_item(KIND_CHAR, CH_CR);
			send_item(KIND_EOS, 8'($urandom_range(255)));
		end
	endtask

	// Edge values of the fields and special cases of the parser.
	task automatic test_directed();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		send_item(KIND_NEWLINE, 8'h00);   // empty line: one record end
		send_item(KIND_CHAR, 8'h00);
		send_item(KIND_CHAR, 8'hFF);
		send_item(KIND_CHAR, CH_COMMA);
		send_item(KIND_CHAR, CH_QUOTE);   // opens a quoted field
		send_item(KIND_CHAR, CH_QUOTE);
		send_item(KIND_CHAR, CH_QUOTE);   // doubled quote
		send_item(KIND_NEWLINE, 8'h00);   // newline inside quotes
		send_item(KIND_CHAR, CH_QUOTE);
		send_item(KIND_CHAR, 8'h78);      // byte after closing quote: malformed
		send_item(KIND_CHAR, CH_QUOTE);   // skipped
		send_item(KIND_NEWLINE, 8'hFF);   // ends the skip quietly
		send_item(KIND_CHAR, 8'h61);
		send_item(KIND_CHAR, CH_QUOTE);   // quote inside an unquoted field
		send_item(KIND_CHAR, CH_CR);
		send_item(KIND_CHAR, 8'h62);      // held carriage return comes out first
		send_item(KIND_CHAR, CH_CR);
		send_item(KIND_NEWLINE, 8'h00);   // carriage return before newline dropped
		send_item(2'd3, 8'h55);           // unused kind is ignored
		send_item(KIND_CHAR, CH_QUOTE);
		send_item(KIND_EOS, 8'hAA);       // end of stream inside quotes
		send_item(KIND_EOS, 8'h00);       // end of stream on an empty line
		send_item(KIND_CHAR, 8'h71);
		send_item(KIND_CHAR, CH_CR);
		send_item(KIND_EOS, 8'h00);       // end of stream closes the record
		stop_sending();
	endtask

	task automatic test_random_records(input int src_pct, input int sink_pct, input int count);
		int stop_at;
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		stop_at        = items_sent + count;
		while (items_sent < stop_at)
			send_record();
		stop_sending();
	endtask

	// The receiver holds off long enough for the block to fill and stall its input.
	task automatic test_backpressure();
		int stop_at;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_req       = 1'b1;
		stop_at        = items_sent + 60;
		while (items_sent < stop_at)
			send_record();
		stop_sending();
	endtask

	// Receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Each result transfer is compared with the oldest expected token.
	always @(posedge clk) begin
		csvt_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_tokens.size() == 0) begin
				$display("%0t: unexpected token: kind %0d char %02h last %0b", $time,
					m_axis_tuser, m_axis_tdata, m_axis_tlast);
				fail_count++;
			end else begin
				want = expected_tokens.pop_front();
				if (m_axis_tuser !== want.out_kind || m_axis_tdata !== want.out_char ||
					m_axis_tlast !== want.last) begin
					$display("%0t: mismatch: expected %0d/%02h/%0b, got %0d/%02h/%0b",
						$time, want.out_kind, want.out_char, want.last,
						m_axis_tuser, m_axis_tdata, m_axis_tlast);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Predictor flags start as after reset.
	function void ref_state_init();
		reset_record();
		skipping = 1'b0;
	endfunction

	initial begin
		ref_state_init();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_records(0, 0, 330);
		test_random_records(88, 0, 300);
		test_random_records(0, 88, 300);
		test_random_records(30, 30, 330);
		test_backpressure();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
design/csvt_pkg.sv
design/csvt_step.sv
design/csvt_result_fifo.sv
design/csv_record_tokenizer.sv
bench/csv_record_tokenizer_tb.sv
